// ===== rtl/core/f2e_pkg.sv =====
// shared types and constants of the frame to event converter
package f2e_pkg;

  localparam int unsigned LvlW = 24;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DivW = LvlW + TimeW;

  localparam int unsigned MaxWidthDef = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned MaxEventsDef = 64;

  localparam logic [1:0] RegPosThr = 2'd0;
  localparam logic [1:0] RegNegThr = 2'd1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMP  = 7'b0000010,
    S_DIVN = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_DIVP = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/f2e_div.sv =====
// shared restoring divider, one quotient bit per cycle
module f2e_div import f2e_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     dividend_i,
  input  logic [LvlW-1:0]     divisor_i,
  output div_stat_t           stat_o,
  output logic [DivW-1:0]     quotient_o,
  output logic [LvlW-1:0]     remainder_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q;
  logic [LvlW-1:0] rem_q, rem_d, dvs_q;
  logic [LvlW:0]   trial;
  logic            ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? LvlW'(trial - {1'b0, dvs_q}) : trial[LvlW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/core/f2e_ref_store.sv =====
// per-pixel reference level and time memory, registered read
module f2e_ref_store import f2e_pkg::*; #(
  parameter int unsigned Depth = MaxWidthDef * MaxHeightDef,
  parameter int unsigned AddrW = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [LvlW-1:0]   wlevel_i,
  input  logic [TimeW-1:0]  wtime_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [LvlW-1:0]   rlevel_o,
  output logic [TimeW-1:0]  rtime_o
);

  logic [LvlW+TimeW-1:0] mem_q [Depth];
  logic [LvlW+TimeW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wlevel_i, wtime_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rlevel_o = rdata_q[LvlW+TimeW-1:TimeW];
  assign rtime_o = rdata_q[TimeW-1:0];

endmodule

// ===== rtl/core/frame_to_event_converter.sv =====
// frame to event converter top level: sequencer, config and event output
// Each accepted pixel is handled alone. A first-frame pixel, an out-of-range pixel or a
// pixel with no threshold crossing is finished without using the divider. A firing pixel
// makes two passes through the shared 56-step divider (crossing count, then the
// interpolation step) before its first event, and then gives one event per cycle while
// the output is not stalled. Up to MAX_EVENTS events come out per pixel; the reference
// still steps by all crossings. The reference memory holds MAX_WIDTH*MAX_HEIGHT entries
// and has no clear.
module frame_to_event_converter import f2e_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  parameter int unsigned MAX_EVENTS = MaxEventsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [15:0] pixel_value_i,
  input  logic [31:0] frame_time_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  event_x_o,
  output logic [7:0]  event_y_o,
  output logic [31:0] event_time_o,
  output logic        polarity_o,
  output logic        last_event_o,
  output logic        overflow_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(MAX_EVENTS + 1);

  state_e state_q, state_d;
  logic [LvlW-1:0] pos_thr_q, neg_thr_q, pos_eff, neg_eff;
  logic primed_q;

  logic in_acc, in_range;
  logic [AddrW-1:0] addr, addr_q;
  logic [7:0] x_q, y_q;
  logic [15:0] cur_q;
  logic [TimeW-1:0] ft_q;

  logic [LvlW-1:0] rd_level;
  logic [TimeW-1:0] rd_time;
  logic mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [LvlW-1:0] mem_wlevel;
  logic [TimeW-1:0] mem_wtime;

  logic [LvlW-1:0] cur24;
  logic rise_ok, fall_ok;
  logic rise_q, ovf_q;
  logic [LvlW-1:0] thr_q, mag_q, rl_q, n_q, step_q;
  logic [TimeW-1:0] rt_q, dt_q, qp_q, q_q;
  logic [LvlW-1:0] rp_q, r_q;
  logic [DivW-1:0] prod_q;
  logic [CntW-1:0] cnt_q, emit_q;
  logic [LvlW:0] r_sum;

  logic div_start;
  logic [DivW-1:0] div_dividend;
  logic [LvlW-1:0] div_divisor;
  div_stat_t div_stat;
  logic [DivW-1:0] div_quo;
  logic [LvlW-1:0] div_rem;

  assign pos_eff = (pos_thr_q == '0) ? LvlW'(1) : pos_thr_q;
  assign neg_eff = (neg_thr_q == '0) ? LvlW'(1) : neg_thr_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i & ~in_stall_o;
  assign in_range = (32'(pixel_x_i) < 32'(MAX_WIDTH)) && (32'(pixel_y_i) < 32'(MAX_HEIGHT));
  assign addr = AddrW'(32'(pixel_y_i) * 32'(MAX_WIDTH) + 32'(pixel_x_i));

  // config and prime flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_thr_q <= LvlW'(256);
      neg_thr_q <= LvlW'(256);
      primed_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == RegPosThr) begin
        pos_thr_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == RegNegThr) begin
        neg_thr_q <= cfg_data_i;
      end
      if (in_acc && end_of_frame_i) begin
        primed_q <= 1'b1;
      end
    end
  end

  assign mem_we = (in_acc & in_range & ~primed_q) | (state_q == S_UPD);
  assign mem_waddr = (state_q == S_UPD) ? addr_q : addr;
  assign mem_wlevel = (state_q == S_UPD) ? (rise_q ? rl_q + step_q : rl_q - step_q)
                                         : {pixel_value_i, 8'h00};
  assign mem_wtime = (state_q == S_UPD) ? ft_q : frame_time_i;

  f2e_ref_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wlevel_i (mem_wlevel),
    .wtime_i  (mem_wtime),
    .raddr_i  (addr),
    .rlevel_o (rd_level),
    .rtime_o  (rd_time)
  );

  // crossing test
  assign cur24 = {cur_q, 8'h00};
  assign rise_ok = (cur24 >= rd_level) && ((cur24 - rd_level) >= pos_eff);
  assign fall_ok = (rd_level > cur24) && ((rd_level - cur24) >= neg_eff);

  assign div_start = ((state_q == S_CMP) && (rise_ok || fall_ok)) || (state_q == S_UPD);
  assign div_dividend = (state_q == S_UPD) ? prod_q
                      : DivW'(rise_ok ? cur24 - rd_level : rd_level - cur24);
  assign div_divisor = (state_q == S_UPD) ? mag_q : (rise_ok ? pos_eff : neg_eff);

  f2e_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_range && primed_q) begin
          state_d = S_CMP;
        end
      end
      S_CMP: state_d = (rise_ok || fall_ok) ? S_DIVN : S_IDLE;
      S_DIVN: begin
        if (div_stat.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_UPD;
      S_UPD: state_d = S_DIVP;
      S_DIVP: begin
        if (div_stat.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall_i && last_event_o) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign r_sum = {1'b0, r_q} + {1'b0, rp_q};

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= pixel_x_i;
      y_q    <= pixel_y_i;
      cur_q  <= pixel_value_i;
      ft_q   <= frame_time_i;
      addr_q <= addr;
    end
    if (state_q == S_CMP) begin
      rise_q <= rise_ok;
      thr_q  <= rise_ok ? pos_eff : neg_eff;
      mag_q  <= rise_ok ? cur24 - rd_level : rd_level - cur24;
      rl_q   <= rd_level;
      rt_q   <= rd_time;
      dt_q   <= ft_q - rd_time;
    end
    if (state_q == S_DIVN && div_stat.done) begin
      n_q    <= div_quo[LvlW-1:0];
      ovf_q  <= div_quo[LvlW-1:0] > LvlW'(MAX_EVENTS);
      emit_q <= (div_quo[LvlW-1:0] > LvlW'(MAX_EVENTS)) ? CntW'(MAX_EVENTS)
                                                         : CntW'(div_quo[LvlW-1:0]);
    end
    if (state_q == S_MUL) begin
      prod_q <= DivW'(thr_q) * DivW'(dt_q);
      step_q <= LvlW'(n_q * thr_q);
    end
    if (state_q == S_DIVP && div_stat.done) begin
      qp_q  <= div_quo[TimeW-1:0];
      rp_q  <= div_rem;
      q_q   <= div_quo[TimeW-1:0];
      r_q   <= div_rem;
      cnt_q <= CntW'(1);
    end
    if (state_q == S_EMIT && !out_stall_i && !last_event_o) begin
      cnt_q <= cnt_q + CntW'(1);
      if (r_sum >= {1'b0, mag_q}) begin
        r_q <= LvlW'(r_sum - {1'b0, mag_q});
        q_q <= q_q + qp_q + TimeW'(1);
      end else begin
        r_q <= r_sum[LvlW-1:0];
        q_q <= q_q + qp_q;
      end
    end
  end

  assign out_valid_o = (state_q == S_EMIT);
  assign event_x_o = x_q;
  assign event_y_o = y_q;
  assign event_time_o = rt_q + q_q;
  assign polarity_o = rise_q;
  assign last_event_o = (cnt_q == emit_q);
  assign overflow_o = last_event_o & ovf_q;

  a_div_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIVN || state_q == S_DIVP))
    else $error("divider finished outside a wait state");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_event_o |=> out_valid_o)
    else $error("event burst ended early");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0 && cnt_q <= emit_q))
    else $error("event count out of range");

  a_overflow_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> cnt_q == CntW'(MAX_EVENTS))
    else $error("overflow flagged before the event cap");

endmodule

// ===== verif/frame_to_event_converter_test.sv =====
// testbench of the frame to event converter: random pixel frames against an event predictor
`timescale 1ns / 1ps

module frame_to_event_converter_test import f2e_pkg::*;;

  localparam int unsigned NumPix = 12;
  localparam logic [1:0] RegSpare2 = 2'd2;
  localparam logic [1:0] RegSpare3 = 2'd3;
  localparam int unsigned SettleCycles = 400;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] value;
    logic [31:0] ftime;
    logic        eof;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] etime;
    logic        pol;
    logic        last;
    logic        ovf;
  } event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = RegPosThr;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_x_i = '0;
  logic [7:0]  pixel_y_i = '0;
  logic [15:0] pixel_value_i = '0;
  logic [31:0] frame_time_i = '0;
  logic        end_of_frame_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  event_x_o;
  logic [7:0]  event_y_o;
  logic [31:0] event_time_o;
  logic        polarity_o;
  logic        last_event_o;
  logic        overflow_o;

  frame_to_event_converter u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pixel_req_t  pixel_q[$];
  event_t      event_due_q[$];
  int          errors = 0;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;

  // predictor state
  logic [23:0] lvl_mem[int];
  logic [31:0] tref_mem[int];
  bit          armed = 1'b0;
  logic [23:0] pos_thr = 24'd256;
  logic [23:0] neg_thr = 24'd256;

  // stimulus side
  logic [7:0]  pix_x[NumPix];
  logic [7:0]  pix_y[NumPix];
  logic [15:0] last_val[NumPix];
  logic [31:0] ft_now;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic predict_events(input pixel_req_t p);
    int          idx;
    bit          was_armed;
    bit          rise;
    logic [23:0] cur, lvl, pt, nt, thr, mag;
    logic [31:0] n, emit, dt, tref;
    logic [63:0] num;
    event_t      ev;
    idx = int'({p.y, p.x});
    was_armed = armed;
    if (p.eof) armed = 1'b1;
    cur = {p.value, 8'h00};
    if (!was_armed) begin
      lvl_mem[idx] = cur;
      tref_mem[idx] = p.ftime;
      return;
    end
    lvl = lvl_mem[idx];
    tref = tref_mem[idx];
    pt = (pos_thr == 0) ? 24'd1 : pos_thr;
    nt = (neg_thr == 0) ? 24'd1 : neg_thr;
    if (cur >= lvl && cur - lvl >= pt) begin
      rise = 1'b1;
      thr = pt;
      mag = cur - lvl;
    end else if (lvl > cur && lvl - cur >= nt) begin
      rise = 1'b0;
      thr = nt;
      mag = lvl - cur;
    end else begin
      return;
    end
    n = 32'(mag) / 32'(thr);
    emit = (n > MaxEventsDef) ? MaxEventsDef : n;
    dt = p.ftime - tref;
    for (int unsigned i = 0; i < emit; i++) begin
      num = 64'(i + 1) * 64'(thr) * 64'(dt);
      ev.x = p.x;
      ev.y = p.y;
      ev.etime = tref + 32'(num / 64'(mag));
      ev.pol = rise;
      ev.last = (i + 1 == emit);
      ev.ovf = (i + 1 == emit) && (n > MaxEventsDef);
      event_due_q.insert(event_due_q.size(), ev);
    end
    lvl_mem[idx] = rise ? 24'(32'(lvl) + n * 32'(thr)) : 24'(32'(lvl) - n * 32'(thr));
    tref_mem[idx] = p.ftime;
  endtask

  // request driver
  pixel_req_t cur_req;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) predict_events(cur_req);
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && pixel_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        cur_req = pixel_q.pop_front();
        in_valid_i <= 1'b1;
        pixel_x_i <= cur_req.x;
        pixel_y_i <= cur_req.y;
        pixel_value_i <= cur_req.value;
        frame_time_i <= cur_req.ftime;
        end_of_frame_i <= cur_req.eof;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // event monitor
  always @(posedge clk_i) begin
    event_t ev;
    out_stall_i <= ($urandom_range(0, 99) < recv_stall);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (event_due_q.size() == 0) begin
        report($sformatf("unexpected event x=%0d y=%0d", event_x_o, event_y_o));
      end else begin
        ev = event_due_q.pop_front();
        if (event_x_o !== ev.x) report($sformatf("event_x %0d exp %0d", event_x_o, ev.x));
        if (event_y_o !== ev.y) report($sformatf("event_y %0d exp %0d", event_y_o, ev.y));
        if (event_time_o !== ev.etime)
          report($sformatf("event_time %0h exp %0h", event_time_o, ev.etime));
        if (polarity_o !== ev.pol) report($sformatf("polarity %0b exp %0b", polarity_o, ev.pol));
        if (last_event_o !== ev.last)
          report($sformatf("last_event %0b exp %0b", last_event_o, ev.last));
        if (overflow_o !== ev.ovf) report($sformatf("overflow %0b exp %0b", overflow_o, ev.ovf));
      end
    end
  end

  task automatic push_pix(input int k, input logic [15:0] val, input logic eof);
    pixel_req_t p;
    p.x = pix_x[k];
    p.y = pix_y[k];
    p.value = val;
    p.ftime = ft_now;
    p.eof = eof;
    last_val[k] = val;
    pixel_q.insert(pixel_q.size(), p);
    if (eof) begin
      if ($urandom_range(0, 5) == 0) ft_now = $urandom();
      else ft_now = ft_now + $urandom_range(1, 20000);
    end
  endtask

  task automatic push_random(input int count);
    int          k;
    int          d;
    logic [15:0] v;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, NumPix - 1);
      d = $urandom_range(0, 80) - 40;
      case ($urandom_range(0, 9))
        0, 1: v = 16'($urandom());
        2: v = last_val[k];
        3: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: begin
          if (int'(last_val[k]) + d < 0) v = 16'h0000;
          else if (int'(last_val[k]) + d > 65535) v = 16'hFFFF;
          else v = 16'(int'(last_val[k]) + d);
        end
      endcase
      push_pix(k, v, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic wait_drained();
    while (pixel_q.size() > 0 || in_valid_i || event_due_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [23:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    if (index == RegPosThr) pos_thr = data;
    else if (index == RegNegThr) neg_thr = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    pix_x[0] = 8'h00; pix_y[0] = 8'h00;
    pix_x[1] = 8'hFF; pix_y[1] = 8'hFF;
    pix_x[2] = 8'hAA; pix_y[2] = 8'h55;
    pix_x[3] = 8'h55; pix_y[3] = 8'hAA;
    for (int k = 4; k < NumPix; k++) begin
      pix_x[k] = 8'(k * 17 + 3);
      pix_y[k] = 8'($urandom());
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // first frame just stores references, ending just before time wraps
    ft_now = 32'hFFFF_FF00;
    push_pix(0, 16'h0000, 1'b0);
    push_pix(1, 16'hFFFF, 1'b0);
    push_pix(2, 16'h1000, 1'b0);
    push_pix(3, 16'h1000, 1'b0);
    push_pix(4, 16'h2000, 1'b0);
    push_pix(5, 16'h2000, 1'b0);
    for (int k = 6; k < NumPix; k++) push_pix(k, 16'($urandom()), k == NumPix - 1);
    ft_now = 32'h0000_0100;
    // full-scale swings past the event cap, single steps, no change, wrapped time
    push_pix(0, 16'hFFFF, 1'b0);
    push_pix(1, 16'h0000, 1'b0);
    push_pix(2, 16'h1001, 1'b0);
    push_pix(3, 16'h1000, 1'b0);
    push_pix(4, 16'h1FFF, 1'b0);
    push_pix(5, 16'h2000 + 16'd64, 1'b0);
    push_pix(6, last_val[6] ^ 16'h0005, 1'b0);
    push_pix(7, last_val[7] ^ 16'h0007, 1'b1);
    push_random(50);
    wait_drained();

    // zero threshold acts as the smallest step; spare indexes are ignored
    write_reg(RegPosThr, 24'd1);
    write_reg(RegNegThr, 24'd0);
    write_reg(RegSpare2, 24'hFFFFFF);
    write_reg(RegSpare3, 24'h000001);
    send_idle = 63;
    push_random(40);
    wait_drained();

    write_reg(RegPosThr, 24'hFFFFFF);
    write_reg(RegNegThr, 24'hFFFFFF);
    send_idle = 0;
    recv_stall = 63;
    push_random(30);
    wait_drained();

    // fractional steps, some changes fall short of them
    write_reg(RegPosThr, 24'h000300);
    write_reg(RegNegThr, 24'h000180);
    send_idle = 11;
    recv_stall = 11;
    push_random(50);
    wait_drained();

    write_reg(RegPosThr, 24'h00A000);
    write_reg(RegNegThr, 24'h000040);
    send_idle = 0;
    recv_stall = 0;
    push_random(30);
    wait_drained();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
